@@ rtl/utf8d_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8d_pkg: shared constants for the UTF-8 stream decoder
// Field widths, lead byte masks and the character counter width.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

	// Width of the saturating character counter (4 to 32).
	localparam int COUNT_BITS = 16;

	localparam int BYTE_W     = 8;
	localparam int CP_W       = 22;
	localparam int VAL_W      = 21;
	localparam int NUM_W      = 16;
	localparam int OUT_DATA_W = 40;  // code_point + char_number, padded to bytes

	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;

	localparam logic [CP_W-1:0] CP_INVALID = {CP_W{1'b1}};

	typedef logic [1:0] pend_t;

	localparam pend_t PEND_NONE  = 2'd0;
	localparam pend_t PEND_ONE   = 2'd1;
	localparam pend_t PEND_TWO   = 2'd2;
	localparam pend_t PEND_THREE = 2'd3;

endpackage : utf8d_pkg

`default_nettype wire

@@ rtl/utf8_stream_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: UTF-8 byte stream to code point decoder
// Takes one text byte per beat and returns one code point per character,
// with a saturating one-based character number.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                      | tlast
//  ---------+-----+-----------------------------------------+-----------
//  s_axis   | in  | text_byte[7:0]                          | last_byte
//  m_axis   | out | code_point[21:0], char_number[37:22],   | text_end
//           |     | zero pad [39:38]                        |
//
// Each byte is decoded in the cycle it is accepted; a result appears on
// m_axis the cycle after its final byte, and one byte per cycle is sustained
// while m_axis does not stall. The single output register sets the rate:
// s_axis_tready is high whenever that register is empty or being drained.
// arst_n clears the pending count, partial value, counter and output valid.
// A stall on m_axis holds the result and stops intake only while it lasts.
//
`default_nettype none

module utf8_stream_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input bytes
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  wire logic        s_axis_tlast,   // last_byte
	// decoded characters
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [21:0] code_point, [37:22] char_number
	output logic             m_axis_tlast    // text_end
);

	localparam int CW = utf8d_pkg::COUNT_BITS;

	// decoder state
	utf8d_pkg::pend_t                  pend_q;
	logic [utf8d_pkg::VAL_W-1:0]       part_q;
	logic [CW-1:0]                     cnt_q;

	// result register
	logic                              out_vld_q;
	logic [utf8d_pkg::CP_W-1:0]        out_cp_q;
	logic [utf8d_pkg::NUM_W-1:0]       out_num_q;
	logic                              out_end_q;

	logic                              acc;
	logic [7:0]                        b;
	utf8d_pkg::pend_t                  pend_d;
	logic [utf8d_pkg::VAL_W-1:0]       part_d;
	logic                              emit;
	logic [utf8d_pkg::CP_W-1:0]        cp_d;
	logic [utf8d_pkg::VAL_W-1:0]       flush_val;
	logic [CW-1:0]                     cnt_inc;
	logic [CW+utf8d_pkg::NUM_W-1:0]    cnt_ext;

	// accept while the result register is empty or being taken
	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	// decode one byte against the pending state
	always_comb begin
		pend_d = pend_q;
		part_d = part_q;
		emit   = 1'b0;
		cp_d   = '0;
		if (pend_q != utf8d_pkg::PEND_NONE) begin
			// following byte: shift in its low six bits, no check
			part_d = {part_q[utf8d_pkg::VAL_W-7:0], b[5:0]};
			pend_d = pend_q - 2'd1;
			if (pend_d == utf8d_pkg::PEND_NONE) begin
				emit = 1'b1;
				cp_d = {1'b0, part_d};
			end
		end else begin
			case (b) inside
				[8'h00:8'h7F]: begin
					emit = 1'b1;
					cp_d = {{(utf8d_pkg::CP_W-8){1'b0}}, b};
				end
				[8'h80:8'hBF]: begin
					// stray continuation byte: drop it
				end
				[8'hC0:8'hDF]: begin
					pend_d = utf8d_pkg::PEND_ONE;
					part_d = {{(utf8d_pkg::VAL_W-8){1'b0}}, b & utf8d_pkg::LEAD2_MASK};
				end
				[8'hE0:8'hEF]: begin
					pend_d = utf8d_pkg::PEND_TWO;
					part_d = {{(utf8d_pkg::VAL_W-8){1'b0}}, b & utf8d_pkg::LEAD3_MASK};
				end
				[8'hF0:8'hF7]: begin
					pend_d = utf8d_pkg::PEND_THREE;
					part_d = {{(utf8d_pkg::VAL_W-8){1'b0}}, b & utf8d_pkg::LEAD4_MASK};
				end
				default: begin
					emit = 1'b1;
					cp_d = utf8d_pkg::CP_INVALID;
				end
			endcase
		end

		// unfinished character at end of text: pad missing groups with zero
		case (pend_d)
			utf8d_pkg::PEND_ONE:   flush_val = {part_d[utf8d_pkg::VAL_W-7:0], 6'd0};
			utf8d_pkg::PEND_TWO:   flush_val = {part_d[utf8d_pkg::VAL_W-13:0], 12'd0};
			utf8d_pkg::PEND_THREE: flush_val = {part_d[utf8d_pkg::VAL_W-19:0], 18'd0};
			default:               flush_val = part_d;
		endcase
		if (s_axis_tlast && pend_d != utf8d_pkg::PEND_NONE) begin
			emit = 1'b1;
			cp_d = {1'b0, flush_val};
		end
	end

	// saturating count; only the low 16 bits are shown
	assign cnt_inc = (cnt_q == {CW{1'b1}}) ? cnt_q : cnt_q + {{(CW-1){1'b0}}, 1'b1};
	assign cnt_ext = {{utf8d_pkg::NUM_W{1'b0}}, cnt_inc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= utf8d_pkg::PEND_NONE;
			part_q <= '0;
			cnt_q  <= '0;
		end else if (acc) begin
			if (s_axis_tlast) begin
				// end of text: back to the reset state
				pend_q <= utf8d_pkg::PEND_NONE;
				part_q <= '0;
				cnt_q  <= '0;
			end else begin
				pend_q <= pend_d;
				part_q <= part_d;
				if (emit) begin
					cnt_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (acc) begin
			out_vld_q <= emit;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	// payload: load a fresh result, otherwise hold
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_cp_q  <= cp_d;
			out_num_q <= cnt_ext[utf8d_pkg::NUM_W-1:0];
			out_end_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {2'b00, out_num_q, out_cp_q};
	assign m_axis_tlast  = out_end_q;

endmodule : utf8_stream_decoder_unit

`default_nettype wire

@@ rtl/utf8d_checker.sv @@
// ----------------------------------------------------------------------------
// utf8d_checker: port level checks for the UTF-8 stream decoder
// Watches the stream ports of utf8_stream_decoder_unit over time.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// intake stalls only behind a held result
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with no result held");

	// a held result stays put until taken
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// a code point with its top bit set is the invalid marker, all ones
	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[21:0] == 22'h3FFFFF)
		else $error("malformed code point");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:38] == 2'b00)
		else $error("nonzero pad bits");

endmodule : utf8d_checker

bind utf8_stream_decoder_unit utf8d_checker u_utf8d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for utf8_stream_decoder_unit
// Feeds UTF-8 texts over the byte stream, predicts every decoded character
// with a behavioral decoder and compares each result beat field by field.
// Covers stray and unfinished characters, invalid lead bytes, random idling
// on both sides and a long receiver stall.
// ----------------------------------------------------------------------------

module tb;

	localparam int RANDOM_BYTES = 1700;   // bytes of random texts
	localparam int TAIL_ITEMS   = 200;    // last stretch runs without idling
	localparam int HOLD_CYCLES  = 400;    // one long receiver hold-off
	localparam int HOLD_AFTER   = 300;    // characters seen before it starts
	localparam int MAX_GAP      = 17;

	typedef struct packed {
		logic [utf8d_pkg::BYTE_W-1:0] text_byte;
		logic                         last_byte;
	} text_beat_t;

	typedef struct packed {
		logic [utf8d_pkg::CP_W-1:0]  code_point;
		logic [utf8d_pkg::NUM_W-1:0] char_number;
		logic                        text_end;
	} char_result_t;

	// ------------------------------------------------------------------------
	// Clock, reset and the block
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [39:0]       m_axis_tdata;
	logic              m_axis_tlast;

	initial begin
		forever #4 clk = ~clk;
	end

	utf8_stream_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// ------------------------------------------------------------------------
	// Stimulus store, decoder state and expected characters
	// ------------------------------------------------------------------------
	text_beat_t   text_beats[$];      // bytes waiting to be offered
	char_result_t expected_chars[$];  // characters the block still owes us
	logic [7:0]   char_bytes[$];      // scratch: bytes of one character
	logic [7:0]   text_bytes[$];      // scratch: bytes of one text

	utf8d_pkg::pend_t                 pending_cnt  = utf8d_pkg::PEND_NONE;
	logic [utf8d_pkg::VAL_W-1:0]      partial_bits = '0;
	logic [utf8d_pkg::COUNT_BITS-1:0] char_count   = '0;

	int     errors          = 0;
	int     texts_queued    = 0;
	int     bytes_accepted  = 0;
	int     chars_checked   = 0;
	int     send_gap        = 0;
	int     recv_gap        = 0;
	int     hold_left       = 0;
	bit     held_off        = 1'b0;
	bit     saturated_seen  = 1'b0;
	longint cycle_count     = 0;
	longint cycle_limit     = 64'd1 << 40;
	text_beat_t next_beat;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Bump the saturating counter and queue one expected character.
	task automatic emit_char(input logic [utf8d_pkg::CP_W-1:0] cp, input logic at_end);
		char_result_t res;
		if (char_count != '1)
			char_count = char_count + utf8d_pkg::COUNT_BITS'(1);
		res.code_point  = cp;
		res.char_number = utf8d_pkg::NUM_W'(char_count);
		res.text_end    = at_end;
		expected_chars.push_back(res);
	endtask

	// Advance the decoder by one accepted byte.
	task automatic decode_byte(input logic [7:0] b, input logic at_end);
		logic [utf8d_pkg::VAL_W-1:0] padded;
		if (pending_cnt != utf8d_pkg::PEND_NONE) begin
			// any value counts as a following byte here, lead-like or not
			partial_bits = {partial_bits[utf8d_pkg::VAL_W-7:0], b[5:0]};
			pending_cnt  = pending_cnt - 2'd1;
			if (pending_cnt == utf8d_pkg::PEND_NONE)
				emit_char({1'b0, partial_bits}, at_end);
		end else if (b < 8'h80) begin
			emit_char(utf8d_pkg::CP_W'(b), at_end);
		end else if (b < 8'hC0) begin
			// stray continuation byte: dropped
		end else if (b < 8'hE0) begin
			pending_cnt  = utf8d_pkg::PEND_ONE;
			partial_bits = utf8d_pkg::VAL_W'(b & utf8d_pkg::LEAD2_MASK);
		end else if (b < 8'hF0) begin
			pending_cnt  = utf8d_pkg::PEND_TWO;
			partial_bits = utf8d_pkg::VAL_W'(b & utf8d_pkg::LEAD3_MASK);
		end else if (b < 8'hF8) begin
			pending_cnt  = utf8d_pkg::PEND_THREE;
			partial_bits = utf8d_pkg::VAL_W'(b & utf8d_pkg::LEAD4_MASK);
		end else begin
			emit_char(utf8d_pkg::CP_INVALID, at_end);
		end

		if (at_end) begin
			// flush an unfinished character with its missing groups as zero
			if (pending_cnt != utf8d_pkg::PEND_NONE) begin
				padded = partial_bits << (6 * pending_cnt);
				emit_char({1'b0, padded}, 1'b1);
			end
			pending_cnt  = utf8d_pkg::PEND_NONE;
			partial_bits = '0;
			char_count   = '0;
		end
	endtask

	task automatic push_beat(input logic [7:0] b, input logic at_end);
		text_beat_t beat;
		beat.text_byte = b;
		beat.last_byte = at_end;
		text_beats.push_back(beat);
		if (at_end)
			texts_queued++;
	endtask

	// Build one character into char_bytes: mostly well formed, some noise.
	task automatic make_char();
		int         sel;
		int         follow;
		logic [7:0] lead;
		sel    = $urandom_range(0, 99);
		follow = 0;
		char_bytes.delete();
		if (sel < 30) begin
			lead = 8'($urandom_range(0, 8'h7F));
		end else if (sel < 48) begin
			lead   = 8'hC0 | 8'($urandom_range(0, 31));
			follow = 1;
		end else if (sel < 64) begin
			lead   = 8'hE0 | 8'($urandom_range(0, 15));
			follow = 2;
		end else if (sel < 80) begin
			lead   = 8'hF0 | 8'($urandom_range(0, 7));
			follow = 3;
		end else if (sel < 86) begin
			lead = 8'($urandom_range(8'hF8, 8'hFF));
		end else if (sel < 92) begin
			lead = 8'($urandom_range(8'h80, 8'hBF));
		end else begin
			lead = 8'($urandom);
		end
		char_bytes.push_back(lead);
		// broken sequence: lose some following bytes mid-text
		if (follow != 0 && $urandom_range(0, 24) == 0)
			follow = $urandom_range(0, follow - 1);
		for (int k = 0; k < follow; k++) begin
			if ($urandom_range(0, 19) == 0)
				char_bytes.push_back(8'($urandom));
			else
				char_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
		end
	endtask

	// One random text; sometimes it stops inside its final character.
	task automatic add_random_text();
		int nchars;
		bit cut_end;
		int keep;
		nchars  = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
		cut_end = ($urandom_range(0, 6) == 0);
		text_bytes.delete();
		for (int c = 0; c < nchars; c++) begin
			make_char();
			if (c == nchars - 1 && cut_end && char_bytes.size() > 1)
				keep = $urandom_range(1, char_bytes.size() - 1);
			else
				keep = char_bytes.size();
			for (int k = 0; k < keep; k++)
				text_bytes.push_back(char_bytes[k]);
		end
		for (int k = 0; k < text_bytes.size(); k++)
			push_beat(text_bytes[k], k == text_bytes.size() - 1);
	endtask

	// ------------------------------------------------------------------------
	// Driver: offer queued bytes, predict on every accepted beat
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast);
				bytes_accepted++;
			end
			// the slot is free when nothing is offered or the offer just went
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (text_beats.size() != 0) begin
					next_beat = text_beats.pop_front();
					s_axis_tdata  <= next_beat.text_byte;
					s_axis_tlast  <= next_beat.last_byte;
					s_axis_tvalid <= 1'b1;
					if (text_beats.size() >= TAIL_ITEMS && $urandom_range(0, 15) == 0)
						send_gap = $urandom_range(1, MAX_GAP);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Hold-off: one long receiver stall so the block fills and s_axis backs up
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_off  <= 1'b0;
			hold_left <= 0;
		end else if (!held_off && chars_checked >= HOLD_AFTER) begin
			held_off  <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check every result beat, pace tready
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		char_result_t want;
		logic [utf8d_pkg::CP_W-1:0]  got_cp;
		logic [utf8d_pkg::NUM_W-1:0] got_num;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_cp  = m_axis_tdata[utf8d_pkg::CP_W-1:0];
				got_num = m_axis_tdata[utf8d_pkg::CP_W+utf8d_pkg::NUM_W-1:utf8d_pkg::CP_W];
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character cp=%h num=%0d end=%b",
						got_cp, got_num, m_axis_tlast));
				end else begin
					want = expected_chars.pop_front();
					if (got_cp !== want.code_point)
						report_mismatch($sformatf("code_point %h, want %h (char %0d)",
							got_cp, want.code_point, chars_checked));
					if (got_num !== want.char_number)
						report_mismatch($sformatf("char_number %0d, want %0d (char %0d)",
							got_num, want.char_number, chars_checked));
					if (m_axis_tlast !== want.text_end)
						report_mismatch($sformatf("text_end %b, want %b (char %0d)",
							m_axis_tlast, want.text_end, chars_checked));
				end
				if (got_num == '1)
					saturated_seen = 1'b1;
				chars_checked++;
			end

			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (text_beats.size() >= TAIL_ITEMS && $urandom_range(0, 15) == 0)
					recv_gap = $urandom_range(1, MAX_GAP);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("timeout after %0d cycles, %0d characters still owed",
				cycle_count, expected_chars.size());
			$display("** utf8_stream_decoder_unit: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: load stimulus, release reset, drain, report
	// ------------------------------------------------------------------------
	initial begin
		int start_size;

		// ASCII extremes and stray continuation bytes
		push_beat(8'h00, 1'b0);
		push_beat(8'h7F, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'hBF, 1'b0);
		// smallest and largest two-byte characters
		push_beat(8'hC0, 1'b0);
		push_beat(8'h80, 1'b0);
		push_beat(8'hDF, 1'b0);
		push_beat(8'hBF, 1'b0);
		// three-byte character whose following bytes look like lead bytes
		push_beat(8'hEF, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h00, 1'b0);
		// largest four-byte character
		push_beat(8'hF7, 1'b0);
		push_beat(8'hBF, 1'b0);
		push_beat(8'hBF, 1'b0);
		push_beat(8'hBF, 1'b0);
		// invalid lead bytes at both ends of their range
		push_beat(8'hF8, 1'b0);
		push_beat(8'hFF, 1'b0);
		// text ends on a bare three-byte lead: flush with zeros
		push_beat(8'hE2, 1'b1);
		// text ends inside a four-byte character
		push_beat(8'hF4, 1'b0);
		push_beat(8'h8F, 1'b1);
		// text ends on a stray continuation byte: no result, state cleared
		push_beat(8'h41, 1'b0);
		push_beat(8'hA0, 1'b1);
		// one-byte texts, valid and invalid
		push_beat(8'h41, 1'b1);
		push_beat(8'hFF, 1'b1);
		// text ends exactly on a completed character
		push_beat(8'hC3, 1'b0);
		push_beat(8'hA9, 1'b1);

		start_size = text_beats.size();
		while (text_beats.size() - start_size < RANDOM_BYTES)
			add_random_text();

		// every byte may meet the longest gap on both sides, plus the hold-off
		cycle_limit = longint'(text_beats.size()) * (2 + 2 * MAX_GAP) * 4
			+ HOLD_CYCLES + 10000;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// all bytes taken, then every expected character delivered
		while (text_beats.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		// give stray results time to show up
		repeat (16) @(posedge clk);

		$display("run: %0d bytes in %0d texts accepted, %0d characters checked",
			bytes_accepted, texts_queued, chars_checked);
		$display("run: counter saturation %s, %0d mismatches",
			saturated_seen ? "reached" : "not reached", errors);
		if (errors == 0) begin
			$display("** utf8_stream_decoder_unit: PASSED **");
		end else begin
			$display("** utf8_stream_decoder_unit: FAILED **");
		end
		$finish;
	end

endmodule
